// ===== src/mhtq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhtq_pkg
// shared sizes, input codes and the store request bundle for the timer queue
// ----------------------------------------------------------------------------
package mhtq_pkg;

   // heap capacity and derived widths
   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CHLD_W = CNT_W + 1;

   // fixed field widths of the item ports
   localparam int TIME_W  = 32;
   localparam int DELAY_W = 16;
   localparam int PEND_W  = 5;

   // input item function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [TIME_W-1:0] wdata;
      logic [IDX_W-1:0]  raddr_a;
      logic [IDX_W-1:0]  raddr_b;
   } mem_req_type;

endpackage

// ===== src/mhtq_store.sv =====
// ----------------------------------------------------------------------------
// mhtq_store
// heap deadline memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mhtq_store (
   input  logic                         clock,
   input  mhtq_pkg::mem_req_type        mem_req,
   output logic [mhtq_pkg::TIME_W-1:0]  rd_a,
   output logic [mhtq_pkg::TIME_W-1:0]  rd_b
);
   import mhtq_pkg::*;

   logic [TIME_W-1:0] mem_ff [DEPTH];
   logic [TIME_W-1:0] rd_a_ff;
   logic [TIME_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rd_a_ff <= mem_ff[mem_req.raddr_a];
      rd_b_ff <= mem_ff[mem_req.raddr_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

// ===== src/mhtq_cmp.sv =====
// ----------------------------------------------------------------------------
// mhtq_cmp
// shared wrapping time comparator: a strictly before b by signed difference
// ----------------------------------------------------------------------------
module mhtq_cmp (
   input  logic [mhtq_pkg::TIME_W-1:0] op_a,
   input  logic [mhtq_pkg::TIME_W-1:0] op_b,
   output logic                        a_earlier
);
   import mhtq_pkg::*;

   logic [TIME_W-1:0] diff;

   assign diff      = op_a - op_b;
   assign a_earlier = diff[TIME_W-1];

endmodule

// ===== src/min_heap_timer_queue_unit.sv =====
// ----------------------------------------------------------------------------
// min_heap_timer_queue_unit
// timer queue holding deadlines in a binary min-heap, one level per step
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  req     | in        | req_valid/stall    | func, delay
//  rsp     | out       | rsp_valid/stall    | fired, fired_deadline, status,
//          |           |                    | pending
//
//  steps: a rejected start goes straight to finish; a start on an empty heap
//  writes the root, else it climbs a level at a time (read the parent, then
//  compare) until it stops or reaches the root. a tick on an empty heap
//  finishes at once; else it compares the time with the root, and if it
//  fires and entries remain, moves the last entry to the root and descends
//  a level at a time toward a leaf (read both children, pick the earlier,
//  compare with the moved-up entry). the pace is set by the single
//  comparator and the registered reads of the heap memory; a finished item
//  may also wait for the output register.
//  reset: synchronous, clears the count, time and handshake state; the heap
//  memory is not cleared; only slots below the count are ever used.
//  stalls: req_stall is high while an item is in work; a finished result
//  waits in the output register, and a new item is taken meanwhile.
// ----------------------------------------------------------------------------
module min_heap_timer_queue_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [mhtq_pkg::DELAY_W-1:0]  req_delay,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_fired,
   output logic [mhtq_pkg::TIME_W-1:0]   rsp_fired_deadline,
   output logic                          rsp_status,
   output logic [mhtq_pkg::PEND_W-1:0]   rsp_pending
);
   import mhtq_pkg::*;

   // sequencer state codes
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_UP_RD   = 4'd1;
   localparam logic [3:0] S_UP_CMP  = 4'd2;
   localparam logic [3:0] S_TK_CMP  = 4'd3;
   localparam logic [3:0] S_DN_LAST = 4'd4;
   localparam logic [3:0] S_DN_RD   = 4'd5;
   localparam logic [3:0] S_DN_SEL  = 4'd6;
   localparam logic [3:0] S_DN_CMP  = 4'd7;
   localparam logic [3:0] S_FIN     = 4'd8;

   // control state
   logic [3:0]        state_ff,     state_in;
   logic [CNT_W-1:0]  count_ff,     count_in;
   logic [TIME_W-1:0] time_ff,      time_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // working registers of the heap walk
   logic [IDX_W-1:0]  idx_ff,  idx_in;    // current hole
   logic [TIME_W-1:0] val_ff,  val_in;    // value being placed
   logic [IDX_W-1:0]  cidx_ff, cidx_in;   // chosen child index
   logic [TIME_W-1:0] cval_ff, cval_in;   // chosen child value

   // result held until the walk ends
   logic              res_fired_ff,  res_fired_in;
   logic [TIME_W-1:0] res_fdl_ff,    res_fdl_in;
   logic              res_status_ff, res_status_in;

   // output register
   logic              rsp_fired_ff,  rsp_fired_in;
   logic [TIME_W-1:0] rsp_fdl_ff,    rsp_fdl_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [PEND_W-1:0] rsp_pend_ff,   rsp_pend_in;

   // memory and comparator hookup
   mem_req_type       mem_req;
   logic [TIME_W-1:0] rd_a;
   logic [TIME_W-1:0] rd_b;
   logic [TIME_W-1:0] cmp_a;
   logic [TIME_W-1:0] cmp_b;
   logic              a_earlier;

   // index arithmetic
   logic              req_take;
   logic [IDX_W-1:0]  parent;
   logic [CHLD_W-1:0] child_l;
   logic [CHLD_W-1:0] child_r;
   logic              right_ok;
   logic [CNT_W-1:0]  count_dec;

   mhtq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   mhtq_cmp u_cmp (
      .op_a      (cmp_a),
      .op_b      (cmp_b),
      .a_earlier (a_earlier)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign parent    = (idx_ff - IDX_W'(1)) >> 1;
   assign child_l   = (CHLD_W'(idx_ff) << 1) + CHLD_W'(1);
   assign child_r   = child_l + CHLD_W'(1);
   assign right_ok  = (child_r < CHLD_W'(count_ff));
   assign count_dec = count_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      time_in       = time_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      cidx_in       = cidx_ff;
      cval_in       = cval_ff;
      res_fired_in  = res_fired_ff;
      res_fdl_in    = res_fdl_ff;
      res_status_in = res_status_ff;

      // root read by default, so a tick finds the root ready next cycle
      mem_req.we      = 1'b0;
      mem_req.waddr   = idx_ff;
      mem_req.wdata   = val_ff;
      mem_req.raddr_a = '0;
      mem_req.raddr_b = '0;

      cmp_a = val_ff;
      cmp_b = rd_a;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               res_fired_in  = 1'b0;
               res_fdl_in    = '0;
               res_status_in = STATUS_OK;
               if (req_func == FUNC_START) begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = S_FIN;
                  end else begin
                     val_in   = time_ff + TIME_W'(req_delay);
                     idx_in   = count_ff[IDX_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                     state_in = S_UP_RD;
                  end
               end else begin
                  time_in = time_ff + TIME_W'(1);
                  if (count_ff == '0) begin
                     state_in = S_FIN;
                  end else begin
                     state_in = S_TK_CMP;
                  end
               end
            end
         end

         // sift-up: fetch the parent of the hole, or write the value at the root
         S_UP_RD: begin
            if (idx_ff == '0) begin
               mem_req.we = 1'b1;
               state_in   = S_FIN;
            end else begin
               mem_req.raddr_a = parent;
               state_in        = S_UP_CMP;
            end
         end

         // parent moves down when the new value is earlier, else the value goes into the hole
         S_UP_CMP: begin
            if (a_earlier) begin
               mem_req.we    = 1'b1;
               mem_req.wdata = rd_a;
               idx_in        = parent;
               state_in      = S_UP_RD;
            end else begin
               mem_req.we = 1'b1;
               state_in   = S_FIN;
            end
         end

         // root is due unless the time is still before it
         S_TK_CMP: begin
            cmp_a = time_ff;
            if (!a_earlier) begin
               res_fired_in = 1'b1;
               res_fdl_in   = rd_a;
               count_in     = count_dec;
               if (count_dec == '0) begin
                  state_in = S_FIN;
               end else begin
                  mem_req.raddr_a = count_dec[IDX_W-1:0];
                  state_in        = S_DN_LAST;
               end
            end else begin
               state_in = S_FIN;
            end
         end

         // last entry becomes the value to sift down from the root
         S_DN_LAST: begin
            val_in   = rd_a;
            idx_in   = '0;
            state_in = S_DN_RD;
         end

         S_DN_RD: begin
            if (child_l >= CHLD_W'(count_ff)) begin
               mem_req.we = 1'b1;
               state_in   = S_FIN;
            end else begin
               mem_req.raddr_a = child_l[IDX_W-1:0];
               mem_req.raddr_b = child_r[IDX_W-1:0];
               state_in        = S_DN_SEL;
            end
         end

         // pick the earlier of the two children, the left one on a tie or with no right child
         S_DN_SEL: begin
            cmp_a = rd_b;
            if (right_ok && a_earlier) begin
               cidx_in = child_r[IDX_W-1:0];
               cval_in = rd_b;
            end else begin
               cidx_in = child_l[IDX_W-1:0];
               cval_in = rd_a;
            end
            state_in = S_DN_CMP;
         end

         // child moves up when it is earlier than the placed value, else the value goes into the hole
         S_DN_CMP: begin
            cmp_a = cval_ff;
            cmp_b = val_ff;
            mem_req.we = 1'b1;
            if (a_earlier) begin
               mem_req.wdata = cval_ff;
               idx_in        = cidx_ff;
               state_in      = S_DN_RD;
            end else begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: loads on finish once the previous item has left
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_fired_in  = rsp_fired_ff;
      rsp_fdl_in    = rsp_fdl_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pend_in   = rsp_pend_ff;
      if ((state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in  = 1'b1;
         rsp_fired_in  = res_fired_ff;
         rsp_fdl_in    = res_fdl_ff;
         rsp_status_in = res_status_ff;
         rsp_pend_in   = PEND_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      cidx_ff       <= cidx_in;
      cval_ff       <= cval_in;
      res_fired_ff  <= res_fired_in;
      res_fdl_ff    <= res_fdl_in;
      res_status_ff <= res_status_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_fdl_ff    <= rsp_fdl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pend_ff   <= rsp_pend_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_fired          = rsp_fired_ff;
   assign rsp_fired_deadline = rsp_fdl_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_pending        = rsp_pend_ff;

endmodule

// ===== src/mhtq_checker.sv =====
// ----------------------------------------------------------------------------
// mhtq_checker
// port-level checks on the timer queue, bound to the top level
// ----------------------------------------------------------------------------
module mhtq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_fired,
   input logic [mhtq_pkg::TIME_W-1:0]   rsp_fired_deadline,
   input logic                          rsp_status,
   input logic [mhtq_pkg::PEND_W-1:0]   rsp_pending
);
   import mhtq_pkg::*;

   // a stalled item stays valid and holds its deadline, pending count and status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fired_deadline)
         && $stable(rsp_pending) && $stable(rsp_status))
      else $error("stalled result item changed");

   // an accepted item keeps the block busy for at least the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

   // a rejected start fires nothing and reports a full heap
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |->
         !rsp_fired && (rsp_pending == PEND_W'(DEPTH)))
      else $error("rejected start with wrong fields");

   // no deadline shown unless a timer fired
   a_fdl_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> (rsp_fired_deadline == '0))
      else $error("deadline shown without fire");

endmodule

bind min_heap_timer_queue_unit mhtq_checker u_mhtq_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_fired          (rsp_fired),
   .rsp_fired_deadline (rsp_fired_deadline),
   .rsp_status         (rsp_status),
   .rsp_pending        (rsp_pending)
);
